@@ design/tbp_pkg.sv @@
package tbp_pkg;

	// table index widths, all tables are powers of two
	localparam int GIDX_BITS  = 12;
	localparam int LHIDX_BITS = 10;
	localparam int LPIDX_BITS = 10;

	localparam int GLOBAL_ENTRIES        = 1 << GIDX_BITS;
	localparam int LOCAL_HISTORY_ENTRIES = 1 << LHIDX_BITS;
	localparam int LOCAL_PATTERN_ENTRIES = 1 << LPIDX_BITS;

	// counter sizes
	localparam int LOCAL_STATES  = 8;
	localparam int GLOBAL_STATES = 4;
	localparam int LCTR_BITS     = $clog2(LOCAL_STATES);
	localparam int GCTR_BITS     = $clog2(GLOBAL_STATES);

	// branch addresses are word aligned
	localparam int ADDR_SHIFT = 2;
	localparam int ADDR_BITS  = 32;

	// clearing pass covers the deepest table
	localparam int CLEAR_ENTRIES =
		(GLOBAL_ENTRIES >= LOCAL_HISTORY_ENTRIES) ?
		((GLOBAL_ENTRIES >= LOCAL_PATTERN_ENTRIES) ? GLOBAL_ENTRIES : LOCAL_PATTERN_ENTRIES) :
		((LOCAL_HISTORY_ENTRIES >= LOCAL_PATTERN_ENTRIES) ?
			LOCAL_HISTORY_ENTRIES : LOCAL_PATTERN_ENTRIES);
	localparam int CLEAR_BITS = $clog2(CLEAR_ENTRIES);

	typedef enum logic {
		OP_PREDICT = 1'b0,
		OP_UPDATE  = 1'b1
	} op_t;

	// clearing sequencer status
	typedef struct packed {
		logic                  active;
		logic [CLEAR_BITS-1:0] addr;
	} clear_t;

	// 2-bit saturating counter step
	function automatic logic [GCTR_BITS-1:0] sat_g(input logic [GCTR_BITS-1:0] v,
		input logic up);
		logic [GCTR_BITS-1:0] r;
		r = v;
		if (up) begin
			if (v != {GCTR_BITS{1'b1}})
				r = v + GCTR_BITS'(1);
		end else begin
			if (v != '0)
				r = v - GCTR_BITS'(1);
		end
		return r;
	endfunction

	// 3-bit saturating counter step
	function automatic logic [LCTR_BITS-1:0] sat_l(input logic [LCTR_BITS-1:0] v,
		input logic up);
		logic [LCTR_BITS-1:0] r;
		r = v;
		if (up) begin
			if (v != {LCTR_BITS{1'b1}})
				r = v + LCTR_BITS'(1);
		end else begin
			if (v != '0)
				r = v - LCTR_BITS'(1);
		end
		return r;
	endfunction

endpackage

@@ design/tbp_ram.sv @@
module tbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port, read returns old data
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/tbp_clear.sv @@
module tbp_clear (
	input  logic            clk,
	input  logic            arst_n,
	output tbp_pkg::clear_t clr
);

	logic                           active_q;
	logic [tbp_pkg::CLEAR_BITS-1:0] addr_q;

	// sweep every table address once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			addr_q   <= '0;
		end else if (active_q) begin
			addr_q <= addr_q + tbp_pkg::CLEAR_BITS'(1);
			if (addr_q == tbp_pkg::CLEAR_BITS'(tbp_pkg::CLEAR_ENTRIES - 1))
				active_q <= 1'b0;
		end
	end

	assign clr.active = active_q;
	assign clr.addr   = addr_q;

endmodule

@@ design/tournament_branch_predictor_core.sv @@
// channel   | ports                                   | dir | handshake
// ----------+-----------------------------------------+-----+---------------------------
// request   | opcode, branch_address, outcome         | in  | start high and busy low
// result    | taken, confidence                       | out | done high for one cycle
//
// one request per cycle while busy is low; a predict result passes both stages to the done register
// reads go through registered memories: choice, global and local history in the
// first stage, local counter in the second, with write forwarding between items
// after reset busy stays high while every table entry is cleared
// the receiver cannot stall, so done is never held off; updates give no result
module tournament_branch_predictor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [31:0] branch_address,
	input  logic        outcome,
	output logic        done,
	output logic        taken,
	output logic [2:0]  confidence
);

	localparam int GB = tbp_pkg::GIDX_BITS;
	localparam int HB = tbp_pkg::LHIDX_BITS;
	localparam int PB = tbp_pkg::LPIDX_BITS;
	localparam int LC = tbp_pkg::LCTR_BITS;
	localparam int GC = tbp_pkg::GCTR_BITS;

	// one table write, held in a register for forwarding
	typedef struct packed {
		logic          we;
		logic [GB-1:0] gi;
		logic [HB-1:0] lbi;
		logic [PB-1:0] lpi;
		logic [GC-1:0] choice;
		logic [GC-1:0] glob;
		logic [PB-1:0] lhist;
		logic [LC-1:0] lctr;
	} wr_t;

	tbp_pkg::clear_t clr;
	logic            accept;
	logic [GB-1:0]   ghist_q;

	logic            v_s1, op_s1, outc_s1;
	logic [GB-1:0]   gi_s1;
	logic [HB-1:0]   lbi_s1;

	logic            v_s2, op_s2, outc_s2;
	logic [GB-1:0]   gi_s2;
	logic [HB-1:0]   lbi_s2;
	logic [PB-1:0]   lpi_s2;
	logic [GC-1:0]   choice_s2, glob_s2;
	logic [PB-1:0]   lhist_s2;

	logic [GC-1:0]   choice_rd, glob_rd;
	logic [PB-1:0]   lhist_rd;
	logic [LC-1:0]   lctr_rd;

	logic [GC-1:0]   choice_f1, glob_f1;
	logic [PB-1:0]   lhist_f1;
	logic [LC-1:0]   lctr_f2;

	wr_t             wr_s2;
	wr_t             w_q;

	logic            lright, gright;
	logic            done_q, taken_q;
	logic [2:0]      confidence_q;

	logic [GB-1:0]   g_waddr;
	logic [HB-1:0]   h_waddr;
	logic [PB-1:0]   p_waddr;
	logic            t_we;

	tbp_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr)
	);

	assign busy   = clr.active;
	assign accept = start && !clr.active;

	// global history advances as soon as an update is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ghist_q <= '0;
		else if (accept && opcode == tbp_pkg::OP_UPDATE)
			ghist_q <= {ghist_q[GB-2:0], outcome};
	end

	// table write port: clearing pass or the item in stage two
	assign t_we    = clr.active || wr_s2.we;
	assign g_waddr = clr.active ? clr.addr[GB-1:0] : wr_s2.gi;
	assign h_waddr = clr.active ? clr.addr[HB-1:0] : wr_s2.lbi;
	assign p_waddr = clr.active ? clr.addr[PB-1:0] : wr_s2.lpi;

	tbp_ram #(.WIDTH(GC), .DEPTH(tbp_pkg::GLOBAL_ENTRIES)) u_choice (
		.clk   (clk),
		.we    (t_we),
		.waddr (g_waddr),
		.wdata (clr.active ? GC'(0) : wr_s2.choice),
		.raddr (ghist_q),
		.rdata (choice_rd)
	);

	tbp_ram #(.WIDTH(GC), .DEPTH(tbp_pkg::GLOBAL_ENTRIES)) u_global (
		.clk   (clk),
		.we    (t_we),
		.waddr (g_waddr),
		.wdata (clr.active ? GC'(0) : wr_s2.glob),
		.raddr (ghist_q),
		.rdata (glob_rd)
	);

	tbp_ram #(.WIDTH(PB), .DEPTH(tbp_pkg::LOCAL_HISTORY_ENTRIES)) u_lhist (
		.clk   (clk),
		.we    (t_we),
		.waddr (h_waddr),
		.wdata (clr.active ? PB'(0) : wr_s2.lhist),
		.raddr (branch_address[tbp_pkg::ADDR_SHIFT +: HB]),
		.rdata (lhist_rd)
	);

	tbp_ram #(.WIDTH(LC), .DEPTH(tbp_pkg::LOCAL_PATTERN_ENTRIES)) u_lctr (
		.clk   (clk),
		.we    (t_we),
		.waddr (p_waddr),
		.wdata (clr.active ? LC'(0) : wr_s2.lctr),
		.raddr (lhist_f1),
		.rdata (lctr_rd)
	);

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= accept;
	end

	// stage one payload
	always_ff @(posedge clk) begin
		op_s1   <= opcode;
		outc_s1 <= outcome;
		gi_s1   <= ghist_q;
		lbi_s1  <= branch_address[tbp_pkg::ADDR_SHIFT +: HB];
	end

	// stage one forwarding: newest write from stage two, then the held write
	always_comb begin
		choice_f1 = choice_rd;
		glob_f1   = glob_rd;
		lhist_f1  = lhist_rd;
		if (wr_s2.we && wr_s2.gi == gi_s1) begin
			choice_f1 = wr_s2.choice;
			glob_f1   = wr_s2.glob;
		end else if (w_q.we && w_q.gi == gi_s1) begin
			choice_f1 = w_q.choice;
			glob_f1   = w_q.glob;
		end
		if (wr_s2.we && wr_s2.lbi == lbi_s1)
			lhist_f1 = wr_s2.lhist;
		else if (w_q.we && w_q.lbi == lbi_s1)
			lhist_f1 = w_q.lhist;
	end

	// stage two control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	// stage two payload
	always_ff @(posedge clk) begin
		op_s2     <= op_s1;
		outc_s2   <= outc_s1;
		gi_s2     <= gi_s1;
		lbi_s2    <= lbi_s1;
		lpi_s2    <= lhist_f1;
		choice_s2 <= choice_f1;
		glob_s2   <= glob_f1;
		lhist_s2  <= lhist_f1;
	end

	// local counter read missed only the write of the item just ahead
	assign lctr_f2 = (w_q.we && w_q.lpi == lpi_s2) ? w_q.lctr : lctr_rd;

	assign lright = (lctr_f2[LC-1] == outc_s2);
	assign gright = (glob_s2[GC-1] == outc_s2);

	// counter and history updates
	always_comb begin
		wr_s2.we     = v_s2 && op_s2 == tbp_pkg::OP_UPDATE;
		wr_s2.gi     = gi_s2;
		wr_s2.lbi    = lbi_s2;
		wr_s2.lpi    = lpi_s2;
		wr_s2.glob   = tbp_pkg::sat_g(glob_s2, outc_s2);
		wr_s2.lctr   = tbp_pkg::sat_l(lctr_f2, outc_s2);
		wr_s2.lhist  = {lhist_s2[PB-2:0], outc_s2};
		wr_s2.choice = (lright != gright) ? tbp_pkg::sat_g(choice_s2, gright) : choice_s2;
	end

	// held write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			w_q <= '0;
		else
			w_q <= wr_s2;
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= v_s2 && op_s2 == tbp_pkg::OP_PREDICT;
	end

	// prediction: chooser high bit picks the global side
	always_ff @(posedge clk) begin
		if (choice_s2[GC-1]) begin
			taken_q      <= glob_s2[GC-1];
			confidence_q <= {glob_s2, 1'b0};
		end else begin
			taken_q      <= lctr_f2[LC-1];
			confidence_q <= lctr_f2;
		end
	end

	assign done       = done_q;
	assign taken      = taken_q;
	assign confidence = confidence_q;

	// a result always comes from an accepted predict request, through both stages and done
	a_done_from_predict: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(accept, 3) && $past(opcode, 3) == tbp_pkg::OP_PREDICT))
		else $error("result without matching predict request");

	// direction is the top bit of the confidence on either side
	a_taken_matches_conf: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> taken_q == confidence_q[2])
		else $error("taken disagrees with confidence");

	// updates shift their outcome into the global history
	a_ghist_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == tbp_pkg::OP_UPDATE) |=> ghist_q[0] == $past(outcome))
		else $error("global history not shifted");

	// no item in flight while tables are being cleared
	a_empty_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr.active |-> (!v_s1 && !v_s2 && !w_q.we))
		else $error("pipeline active during clearing pass");

endmodule
